FILE: rtl/key_value_config_parser_assert.svh
// Assertion macros used by the key/value parser lexer (kvcp_lexer).
// Expects clk and rst_n in the scope of each use.
`ifndef KEY_VALUE_CONFIG_PARSER_ASSERT_SVH
`define KEY_VALUE_CONFIG_PARSER_ASSERT_SVH

// Same-cycle implication.
`define KVCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KVCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kvcp_pkg.sv
// Package for the key/value parser: request and result types, opcodes,
// status codes, character constants and token size. No dependencies.
`timescale 1ns / 1ps

package kvcp_pkg;

    localparam int TOKEN_CAPACITY = 256;
    localparam int TOKEN_LEN_W    = $clog2(TOKEN_CAPACITY);

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_END     = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [3:0] ST_NONE       = 4'd0;
    localparam logic [3:0] ST_PAIR_DONE  = 4'd1;
    localparam logic [3:0] ST_CLEAN_END  = 4'd2;
    localparam logic [3:0] ST_KEY_IS_EQ  = 4'd3;
    localparam logic [3:0] ST_EQ_EXPECT  = 4'd4;
    localparam logic [3:0] ST_NO_VALUE   = 4'd5;
    localparam logic [3:0] ST_VALUE_IS_EQ = 4'd6;
    localparam logic [3:0] ST_TOO_LONG   = 4'd7;
    localparam logic [3:0] ST_OPEN_QUOTE = 4'd8;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
    } req_t;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        char_valid;
        logic        token_part;
        logic [3:0]  status;
        logic        quote_warning;
        logic [15:0] line_number;
    } rsp_t;

endpackage

FILE: rtl/key_value_config_parser.sv
// Top level of the key/value text parser: request register, lexer, result register.
// Depends on kvcp_pkg, kvcp_lexer and kvcp_rsp_reg.
//
//   channel   dir   handshake               payload
//   req       in    req_valid / req_ready   kvcp_pkg::req_t (opcode, byte_value)
//   rsp       out   rsp_valid / rsp_ready   kvcp_pkg::rsp_t (char, status, line)
//
// One request per cycle while results are taken; a result is presented after its request
// is taken, passing through the request register, then the result register.
// Each request yields zero or one result; the lexer step is combinational, between the two registers.
// Reset (rst_n low, async) leaves the parser at line 1 expecting a key.
// While a result waits, the lexer holds; one more request can enter an empty request
// register, then req_ready stays low until the cycle the result is taken.

`timescale 1ns / 1ps

module key_value_config_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  kvcp_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output kvcp_pkg::rsp_t rsp
);
    import kvcp_pkg::*;

    logic req_vld_reg;
    req_t req_reg;
    logic space;
    logic step_en;
    logic lex_vld;
    rsp_t lex_res;

    assign step_en   = req_vld_reg && space;
    assign req_ready = !req_vld_reg || step_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (req_ready)
            req_vld_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            req_reg <= req;
    end

    kvcp_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .req     (req_reg),
        .res_vld (lex_vld),
        .res     (lex_res)
    );

    kvcp_rsp_reg u_rsp_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_vld  (lex_vld),
        .load      (lex_res),
        .space     (space),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

FILE: rtl/kvcp_lexer.sv
// Lexer and pair tracker: parser state plus the one-step transition logic.
// Depends on kvcp_pkg and key_value_config_parser_assert.svh.
`timescale 1ns / 1ps

module kvcp_lexer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  kvcp_pkg::req_t req,
    output logic          res_vld,
    output kvcp_pkg::rsp_t res
);
    import kvcp_pkg::*;

    typedef enum logic [2:0] {
        M_SKIP,
        M_COMMENT,
        M_WORD,
        M_QUOTE,
        M_PEND,
        M_HALT
    } mode_t;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_EQ,
        PH_VALUE
    } phase_t;

    localparam logic [TOKEN_LEN_W-1:0] TLEN_LAST = TOKEN_LEN_W'(TOKEN_CAPACITY - 1);
    localparam logic [TOKEN_LEN_W-1:0] TLEN_ONE  = TOKEN_LEN_W'(1);

    mode_t                  mode_reg, mode_next;
    phase_t                 phase_reg, phase_next;
    logic [TOKEN_LEN_W-1:0] tlen_reg, tlen_next;
    logic [7:0]             fq_reg, fq_next;
    logic [15:0]            line_reg, line_next;

    logic [7:0]  c;
    logic        is_nl;
    logic        is_blank;
    logic        is_term;
    logic        is_eq_tok;
    logic        warn;
    logic        step_vld;
    logic [15:0] line_inc;

    assign c         = req.byte_value;
    assign is_nl     = (c == CH_LF) || (c == CH_CR);
    assign is_blank  = is_nl || (c == CH_SPACE) || (c == CH_TAB);
    assign is_term   = is_blank || (c == CH_HASH) || (c == CH_EQ);
    assign is_eq_tok = (tlen_reg == TLEN_ONE) && (fq_reg == CH_EQ);
    assign warn      = is_nl || (c == CH_TAB);
    assign line_inc  = (line_reg == 16'hFFFF) ? line_reg : line_reg + 16'd1;
    assign res_vld   = step_en && step_vld;

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        tlen_next  = tlen_reg;
        fq_next    = fq_reg;
        line_next  = line_reg;
        step_vld   = 1'b0;
        res        = '0;
        res.line_number = line_reg;

        case (req.opcode)
            OP_RESTART:
            begin
                mode_next  = M_SKIP;
                phase_next = PH_KEY;
                tlen_next  = '0;
                fq_next    = '0;
                line_next  = 16'd1;
            end
            OP_END:
            begin
                if (mode_reg != M_HALT)
                begin
                    mode_next = M_HALT;
                    step_vld  = 1'b1;
                    case (mode_reg)
                        M_SKIP, M_COMMENT:
                            res.status = (phase_reg == PH_KEY) ? ST_CLEAN_END :
                                         (phase_reg == PH_EQ)  ? ST_EQ_EXPECT : ST_NO_VALUE;
                        M_WORD:
                            res.status = (phase_reg == PH_VALUE) ? ST_PAIR_DONE : ST_EQ_EXPECT;
                        M_QUOTE:
                            res.status = ST_OPEN_QUOTE;
                        default:
                            res.status = ST_KEY_IS_EQ;
                    endcase
                end
            end
            OP_DATA:
            begin
                case (mode_reg)
                    M_SKIP:
                    begin
                        if (is_blank)
                        begin
                            if (is_nl)
                                line_next = line_inc;
                        end
                        else if (c == CH_HASH)
                            mode_next = M_COMMENT;
                        else if (c == CH_EQ)
                        begin
                            if (phase_reg == PH_EQ)
                                phase_next = PH_VALUE;
                            else
                            begin
                                mode_next  = M_HALT;
                                step_vld   = 1'b1;
                                res.status = (phase_reg == PH_KEY) ? ST_KEY_IS_EQ
                                                                   : ST_VALUE_IS_EQ;
                            end
                        end
                        else if (c == CH_QUOTE)
                        begin
                            tlen_next = '0;
                            fq_next   = '0;
                            mode_next = M_QUOTE;
                        end
                        else
                        begin
                            tlen_next = TLEN_ONE;
                            fq_next   = '0;
                            mode_next = M_WORD;
                            if (phase_reg != PH_EQ)
                            begin
                                step_vld       = 1'b1;
                                res.char_out   = c;
                                res.char_valid = 1'b1;
                                res.token_part = (phase_reg == PH_VALUE);
                            end
                        end
                    end
                    M_COMMENT:
                    begin
                        if (is_nl)
                        begin
                            line_next = line_inc;
                            mode_next = M_SKIP;
                        end
                    end
                    M_WORD:
                    begin
                        if (is_term)
                        begin
                            if (phase_reg == PH_EQ)
                            begin
                                mode_next  = M_HALT;
                                step_vld   = 1'b1;
                                res.status = ST_EQ_EXPECT;
                            end
                            else
                            begin
                                if (is_blank)
                                begin
                                    mode_next = M_SKIP;
                                    if (is_nl)
                                        line_next = line_inc;
                                end
                                else if (c == CH_HASH)
                                    mode_next = M_COMMENT;
                                else
                                    mode_next = (phase_reg == PH_KEY) ? M_SKIP : M_PEND;

                                if (phase_reg == PH_KEY)
                                    phase_next = (c == CH_EQ) ? PH_VALUE : PH_EQ;
                                else
                                begin
                                    phase_next = PH_KEY;
                                    step_vld   = 1'b1;
                                    res.status = ST_PAIR_DONE;
                                end
                            end
                        end
                        else if (tlen_reg == TLEN_LAST)
                        begin
                            mode_next  = M_HALT;
                            step_vld   = 1'b1;
                            res.status = ST_TOO_LONG;
                        end
                        else
                        begin
                            tlen_next = tlen_reg + TLEN_ONE;
                            if (phase_reg != PH_EQ)
                            begin
                                step_vld       = 1'b1;
                                res.char_out   = c;
                                res.char_valid = 1'b1;
                                res.token_part = (phase_reg == PH_VALUE);
                            end
                        end
                    end
                    M_QUOTE:
                    begin
                        if (c == CH_QUOTE)
                        begin
                            mode_next = M_SKIP;
                            case (phase_reg)
                                PH_KEY:
                                begin
                                    if (is_eq_tok)
                                    begin
                                        mode_next  = M_HALT;
                                        step_vld   = 1'b1;
                                        res.status = ST_KEY_IS_EQ;
                                    end
                                    else
                                        phase_next = PH_EQ;
                                end
                                PH_EQ:
                                begin
                                    if (is_eq_tok)
                                        phase_next = PH_VALUE;
                                    else
                                    begin
                                        mode_next  = M_HALT;
                                        step_vld   = 1'b1;
                                        res.status = ST_EQ_EXPECT;
                                    end
                                end
                                default:
                                begin
                                    step_vld = 1'b1;
                                    if (is_eq_tok)
                                    begin
                                        mode_next  = M_HALT;
                                        res.status = ST_VALUE_IS_EQ;
                                    end
                                    else
                                    begin
                                        phase_next = PH_KEY;
                                        res.status = ST_PAIR_DONE;
                                    end
                                end
                            endcase
                        end
                        else if (tlen_reg == TLEN_LAST)
                        begin
                            mode_next  = M_HALT;
                            step_vld   = 1'b1;
                            res.status = ST_TOO_LONG;
                        end
                        else
                        begin
                            if (tlen_reg == '0)
                                fq_next = c;
                            tlen_next = tlen_reg + TLEN_ONE;
                            if (phase_reg != PH_EQ)
                            begin
                                step_vld          = 1'b1;
                                res.char_out      = c;
                                res.char_valid    = 1'b1;
                                res.token_part    = (phase_reg == PH_VALUE);
                                res.quote_warning = warn;
                            end
                            else if (warn)
                            begin
                                step_vld          = 1'b1;
                                res.quote_warning = 1'b1;
                            end
                        end
                    end
                    M_PEND:
                    begin
                        mode_next  = M_HALT;
                        step_vld   = 1'b1;
                        res.status = ST_KEY_IS_EQ;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_SKIP;
            phase_reg <= PH_KEY;
            tlen_reg  <= '0;
            fq_reg    <= '0;
            line_reg  <= 16'd1;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            tlen_reg  <= tlen_next;
            fq_reg    <= fq_next;
            line_reg  <= line_next;
        end
    end

`include "key_value_config_parser_assert.svh"

    `KVCP_ASSERT_NOW(a_halt_silent, step_en && mode_reg == M_HALT && req.opcode != OP_RESTART, !res_vld, "halted parser produced a result")
    `KVCP_ASSERT_NEXT(a_error_halts, res_vld && res.status != ST_NONE && res.status != ST_PAIR_DONE, mode_reg == M_HALT, "error status without halt")
    `KVCP_ASSERT_NEXT(a_restart_clears, step_en && req.opcode == OP_RESTART, line_reg == 16'd1 && phase_reg == PH_KEY && mode_reg == M_SKIP, "restart did not clear state")
    `KVCP_ASSERT_NOW(a_char_no_status, res_vld && res.char_valid, res.status == ST_NONE, "character carries a status")

endmodule

FILE: rtl/kvcp_rsp_reg.sv
// Result register: holds one result until the consumer takes it.
// Depends on kvcp_pkg.
`timescale 1ns / 1ps

module kvcp_rsp_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load_vld,
    input  kvcp_pkg::rsp_t load,
    output logic           space,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output kvcp_pkg::rsp_t rsp
);
    import kvcp_pkg::*;

    logic vld_reg, vld_next;
    rsp_t data_reg;

    assign space     = !vld_reg || rsp_ready;
    assign rsp_valid = vld_reg;
    assign rsp       = data_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (load_vld)
            vld_next = 1'b1;
        else if (rsp_ready)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_vld)
            data_reg <= load;
    end

endmodule

FILE: bench/kvcp_monitor.sv
// Checker for the key/value parser: watches both channels, predicts each
// result from the accepted requests and compares field by field.
// Depends on kvcp_pkg.
`timescale 1ns / 1ps

module kvcp_monitor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  kvcp_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  kvcp_pkg::rsp_t rsp,
    output int             mismatches,
    output int             outstanding,
    output int             checked,
    output int             pairs,
    output logic [8:0]     status_seen
);
    import kvcp_pkg::*;

    typedef enum logic [2:0] {
        LX_SKIP, LX_COMMENT, LX_WORD, LX_QUOTE, LX_PEND, LX_HALT
    } lex_mode_t;

    typedef enum logic [1:0] {
        PH_KEY, PH_EQ, PH_VALUE
    } phase_t;

    lex_mode_t   mode;
    phase_t      phase;
    int          tok_len;
    logic [7:0]  first_q;
    logic [15:0] cur_line;
    rsp_t        lex_results[$];

    function automatic logic is_nl(input logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || is_nl(c);
    endfunction

    function automatic void bump_line();
        if (cur_line != 16'hFFFF)
        begin
            cur_line++;
        end
    endfunction

    function automatic void post(input logic [7:0] ch, input logic v, input logic part,
                                 input logic [3:0] st, input logic warn,
                                 input logic [15:0] ln);
        rsp_t r;
        r.char_out      = ch;
        r.char_valid    = v;
        r.token_part    = part;
        r.status        = st;
        r.quote_warning = warn;
        r.line_number   = ln;
        lex_results.push_back(r);
    endfunction

    function automatic void halt(input logic [3:0] st);
        mode = LX_HALT;
        post(8'h00, 1'b0, 1'b0, st, 1'b0, cur_line);
    endfunction

    function automatic void restart_parse();
        mode     = LX_SKIP;
        phase    = PH_KEY;
        tok_len  = 0;
        first_q  = 8'h00;
        cur_line = 16'd1;
    endfunction

    function automatic void skip_byte(input logic [7:0] c);
        if (is_blank(c))
        begin
            if (is_nl(c))
            begin
                bump_line();
            end
        end
        else if (c == CH_HASH)
        begin
            mode = LX_COMMENT;
        end
        else if (c == CH_EQ)
        begin
            case (phase)
                PH_KEY:  halt(ST_KEY_IS_EQ);
                PH_EQ:   phase = PH_VALUE;
                default: halt(ST_VALUE_IS_EQ);
            endcase
        end
        else
        begin
            tok_len = 0;
            first_q = 8'h00;
            if (c == CH_QUOTE)
            begin
                mode = LX_QUOTE;
            end
            else
            begin
                tok_len = 1;
                mode    = LX_WORD;
                if (phase != PH_EQ)
                begin
                    post(c, 1'b1, phase == PH_VALUE, ST_NONE, 1'b0, cur_line);
                end
            end
        end
    endfunction

    function automatic void word_byte(input logic [7:0] c);
        logic [15:0] at_line;
        at_line = cur_line;
        if (is_blank(c) || c == CH_HASH || c == CH_EQ)
        begin
            case (phase)
                PH_KEY:
                begin
                    phase = PH_EQ;
                    mode  = LX_SKIP;
                    skip_byte(c);
                end
                PH_EQ:
                begin
                    halt(ST_EQ_EXPECT);
                end
                default:
                begin
                    phase = PH_KEY;
                    if (c == CH_EQ)
                    begin
                        mode = LX_PEND;
                    end
                    else
                    begin
                        mode = LX_SKIP;
                        skip_byte(c);
                    end
                    post(8'h00, 1'b0, 1'b0, ST_PAIR_DONE, 1'b0, at_line);
                end
            endcase
        end
        else if (tok_len >= TOKEN_CAPACITY - 1)
        begin
            halt(ST_TOO_LONG);
        end
        else
        begin
            tok_len++;
            if (phase != PH_EQ)
            begin
                post(c, 1'b1, phase == PH_VALUE, ST_NONE, 1'b0, cur_line);
            end
        end
    endfunction

    function automatic void quote_byte(input logic [7:0] c);
        logic is_eq;
        logic warn;
        if (c == CH_QUOTE)
        begin
            is_eq = tok_len == 1 && first_q == CH_EQ;
            mode  = LX_SKIP;
            case (phase)
                PH_KEY:
                begin
                    if (is_eq) halt(ST_KEY_IS_EQ);
                    else phase = PH_EQ;
                end
                PH_EQ:
                begin
                    if (!is_eq) halt(ST_EQ_EXPECT);
                    else phase = PH_VALUE;
                end
                default:
                begin
                    if (is_eq)
                    begin
                        halt(ST_VALUE_IS_EQ);
                    end
                    else
                    begin
                        phase = PH_KEY;
                        post(8'h00, 1'b0, 1'b0, ST_PAIR_DONE, 1'b0, cur_line);
                    end
                end
            endcase
        end
        else if (tok_len >= TOKEN_CAPACITY - 1)
        begin
            halt(ST_TOO_LONG);
        end
        else
        begin
            if (tok_len == 0)
            begin
                first_q = c;
            end
            tok_len++;
            warn = c == CH_TAB || is_nl(c);
            if (phase != PH_EQ)
            begin
                post(c, 1'b1, phase == PH_VALUE, ST_NONE, warn, cur_line);
            end
            else if (warn)
            begin
                post(8'h00, 1'b0, 1'b0, ST_NONE, 1'b1, cur_line);
            end
        end
    endfunction

    function automatic void end_input();
        case (mode)
            LX_SKIP, LX_COMMENT:
                halt(phase == PH_KEY ? ST_CLEAN_END :
                     (phase == PH_EQ ? ST_EQ_EXPECT : ST_NO_VALUE));
            LX_WORD:  halt(phase == PH_VALUE ? ST_PAIR_DONE : ST_EQ_EXPECT);
            LX_QUOTE: halt(ST_OPEN_QUOTE);
            LX_PEND:  halt(ST_KEY_IS_EQ);
            default:  ;
        endcase
    endfunction

    function automatic void lex_step(input req_t r);
        case (r.opcode)
            OP_RESTART: restart_parse();
            OP_END:     end_input();
            OP_DATA:
            begin
                case (mode)
                    LX_SKIP:  skip_byte(r.byte_value);
                    LX_COMMENT:
                    begin
                        if (is_nl(r.byte_value))
                        begin
                            bump_line();
                            mode = LX_SKIP;
                        end
                    end
                    LX_WORD:  word_byte(r.byte_value);
                    LX_QUOTE: quote_byte(r.byte_value);
                    LX_PEND:  halt(ST_KEY_IS_EQ);
                    default:  ;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            restart_parse();
            lex_results.delete();
            mismatches  = 0;
            checked     = 0;
            pairs       = 0;
            status_seen = '0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (lex_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result expected none, got %p", $time, rsp);
                end
                else
                begin
                    want = lex_results.pop_front();
                    checked++;
                    check_field("char_out", 16'(want.char_out), 16'(rsp.char_out));
                    check_field("char_valid", 16'(want.char_valid), 16'(rsp.char_valid));
                    check_field("token_part", 16'(want.token_part), 16'(rsp.token_part));
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("quote_warning", 16'(want.quote_warning),
                                16'(rsp.quote_warning));
                    check_field("line_number", want.line_number, rsp.line_number);
                    if (want.status == ST_PAIR_DONE)
                    begin
                        pairs++;
                    end
                    status_seen[want.status] = 1'b1;
                end
            end
            if (req_valid && req_ready)
            begin
                lex_step(req);
            end
        end
        outstanding = lex_results.size();
    end

endmodule

FILE: bench/tb.sv
// Top of the key/value parser bench: clock, reset, request and stall generation,
// watchdog and verdict. Depends on kvcp_pkg, key_value_config_parser and kvcp_monitor.
`timescale 1ns / 1ps

module tb;
    import kvcp_pkg::*;

    localparam int         STALL_LIMIT = 2000;
    localparam int         ITEM_TARGET = 1950;
    localparam logic [1:0] OP_IGNORED  = 2'd3;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;

    int          mismatches;
    int          outstanding;
    int          checked;
    int          pairs;
    logic [8:0]  status_seen;
    int          idle_cycles = 0;
    int          sent        = 0;
    logic        calm        = 1'b0;
    logic [3:0]  sink_wait   = '0;
    logic [7:0]  script[$];

    key_value_config_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    kvcp_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .pairs       (pairs),
        .status_seen (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("key_value_config_parser: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side stalls a random number of cycles after each result
    always @(posedge clk or negedge rst_n)
    begin : sink_ctl
        int g;
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            sink_wait <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            g = calm ? 0 : $urandom_range(0, 8);
            sink_wait <= g[3:0];
            rsp_ready <= (g == 0);
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1'b1;
            rsp_ready <= (sink_wait == 1);
        end
        else
        begin
            rsp_ready <= 1'b1;
        end
    end

    task automatic push(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{opcode: op, byte_value: b};
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        if (op != OP_IGNORED)
        begin
            sent++;
        end
    endtask

    task automatic send_script();
        foreach (script[i])
        begin
            push(OP_DATA, script[i]);
        end
        script.delete();
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            script.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
               c == CH_HASH || c == CH_EQ || c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] quote_char();
        logic [7:0] c;
        case ($urandom_range(0, 29))
            0: c = CH_TAB;
            1: c = CH_CR;
            2: c = CH_LF;
            default:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE);
            end
        endcase
        return c;
    endfunction

    function automatic void add_blanks(input logic allow_nl);
        int n;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            case ($urandom_range(0, allow_nl ? 3 : 1))
                0: script.push_back(CH_SPACE);
                1: script.push_back(CH_TAB);
                2: script.push_back(CH_CR);
                default: script.push_back(CH_LF);
            endcase
        end
    endfunction

    // mostly short tokens, now and then one near the capacity limit
    function automatic void add_token(input logic quoted);
        int len;
        if ($urandom_range(0, 99) == 0)
        begin
            len = $urandom_range(TOKEN_CAPACITY - 3, TOKEN_CAPACITY);
        end
        else
        begin
            len = $urandom_range(quoted ? 0 : 1, 6);
        end
        if (quoted)
        begin
            script.push_back(CH_QUOTE);
            repeat (len) script.push_back(quote_char());
            script.push_back(CH_QUOTE);
        end
        else
        begin
            repeat (len) script.push_back(word_char());
        end
    endfunction

    function automatic void add_record();
        int shape;
        logic [7:0] c;
        shape = $urandom_range(0, 19);
        add_blanks(1'b1);
        add_token($urandom_range(0, 4) == 0);
        add_blanks(1'b0);
        if (shape == 1)
        begin
            add_text("\"=\"");
        end
        else if (shape != 0)
        begin
            script.push_back(CH_EQ);
        end
        add_blanks(1'b0);
        if (shape != 2)
        begin
            add_token($urandom_range(0, 4) == 0);
        end
        if (shape == 3)
        begin
            script.push_back(CH_EQ);
        end
        case ($urandom_range(0, 7))
            0, 1:    script.push_back(CH_LF);
            2:       script.push_back(CH_CR);
            3, 4:    add_text("\r\n");
            5, 6:
            begin
                script.push_back(CH_HASH);
                repeat ($urandom_range(0, 5))
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_LF || c == CH_CR);
                    script.push_back(c);
                end
                script.push_back(CH_LF);
            end
            default: ;
        endcase
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 20))
        begin
            case ($urandom_range(0, 7))
                0: script.push_back(CH_SPACE);
                1: script.push_back(CH_TAB);
                2: script.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
                3: script.push_back(CH_HASH);
                4: script.push_back(CH_EQ);
                5: script.push_back(CH_QUOTE);
                default: script.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // value ended by '=', then halted input, ignored opcode and end
        add_text("k=v=x");
        send_script();
        push(OP_DATA, "y");
        push(OP_IGNORED, 8'hFF);
        push(OP_END, 8'h00);
        // zero-byte key, quoted "=", all-ones value ended by end of input
        push(OP_RESTART, 8'h00);
        script.push_back(8'h00);
        add_text(" \"=\"\t");
        script.push_back(8'hFF);
        send_script();
        push(OP_END, 8'h00);
        // comment, CR line, newline inside quotes, end inside quotes
        push(OP_RESTART, 8'hFF);
        add_text("#c\r\"a\nb");
        send_script();
        push(OP_END, 8'h00);

        while (sent < ITEM_TARGET)
        begin
            calm = ($urandom_range(0, 4) == 0);
            push(OP_RESTART, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 8)
            begin
                repeat ($urandom_range(1, 4)) add_record();
            end
            else
            begin
                add_noise();
            end
            if ($urandom_range(0, 3) == 0 && script.size() > 1)
            begin
                script = script[0:$urandom_range(0, script.size() - 2)];
            end
            send_script();
            case ($urandom_range(0, 9))
                7:
                begin
                    push(OP_IGNORED, 8'($urandom_range(0, 255)));
                    push(OP_END, 8'($urandom_range(0, 255)));
                end
                8:
                begin
                    push(OP_END, 8'($urandom_range(0, 255)));
                    push(OP_DATA, 8'($urandom_range(0, 255)));
                end
                9: ;
                default: push(OP_END, 8'($urandom_range(0, 255)));
            endcase
        end

        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d requests, %0d results checked, %0d pairs finished",
                 sent, checked, pairs);
        $display("status codes seen (one bit per code, 8 down to 0): %b", status_seen);
        if (mismatches == 0)
        begin
            $display("key_value_config_parser: match");
        end
        else
        begin
            $display("key_value_config_parser: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kvcp_pkg.sv
rtl/kvcp_lexer.sv
rtl/kvcp_rsp_reg.sv
rtl/key_value_config_parser.sv
bench/kvcp_monitor.sv
bench/tb.sv
